>>> sv/gqv_pkg.sv
package gqv_pkg;

  localparam int GLYPH_ENTRIES = 256;
  localparam int CODE_W        = 8;
  localparam int IDX_W         = $clog2(GLYPH_ENTRIES);
  localparam int NUM_W         = 40;
  localparam int DEN_W         = 14;
  localparam int QUO_W         = NUM_W;
  localparam int DIV_CNT_W     = $clog2(NUM_W + 1);

  localparam logic [2:0] REG_WINDOW_WIDTH  = 3'd0;
  localparam logic [2:0] REG_WINDOW_HEIGHT = 3'd1;
  localparam logic [2:0] REG_TEXT_SCALE    = 3'd2;
  localparam logic [2:0] REG_ATLAS_WIDTH   = 3'd3;
  localparam logic [2:0] REG_ATLAS_HEIGHT  = 3'd4;
  localparam logic [2:0] REG_ORIGIN_X      = 3'd5;
  localparam logic [2:0] REG_ORIGIN_Y      = 3'd6;

  // Quantity selected for the shared divider.
  typedef enum logic [2:0] {
    Q_XL = 3'd0, Q_XR = 3'd1, Q_YT = 3'd2, Q_YB = 3'd3,
    Q_UL = 3'd4, Q_UR = 3'd5, Q_VT = 3'd6, Q_VB = 3'd7
  } qsel_t;

  typedef struct packed {
    logic       load;      // write the glyph store from the input item
    logic       lookup;    // read the glyph store and latch its valid bit
    logic       first;     // reload cursor from origin
    logic       mul;       // compute numerator for sel
    logic       div_start; // start division of the numerator
    logic       store;     // saturate and store quotient for sel
    logic       advance;   // advance cursor
    qsel_t      sel;
  } cmd_t;

  typedef struct packed {
    logic valid;           // looked-up glyph is present
    logic div_done;
  } sts_t;

endpackage

>>> sv/gqv_divider.sv
module gqv_divider
  import gqv_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [NUM_W-1:0]     num,
  input  logic [DEN_W-1:0]     den,
  output logic                 done,
  output logic [QUO_W-1:0]     quo
);

  // Restoring division, one quotient bit a cycle.
  logic [NUM_W-1:0]     quo_r, quo_nxt;
  logic [DEN_W:0]       rem_r, rem_nxt;
  logic [DEN_W-1:0]     den_r, den_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DEN_W+1:0]     trial;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[NUM_W-1]} - {2'b00, den_r};
    if (start) begin
      quo_nxt  = num;
      rem_nxt  = '0;
      den_nxt  = den;
      cnt_nxt  = DIV_CNT_W'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[DEN_W+1]) begin
        rem_nxt = trial[DEN_W:0];
        quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[DEN_W-1:0], quo_r[NUM_W-1]};
        quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

>>> sv/gqv_datapath.sv
module gqv_datapath
  import gqv_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic [CODE_W-1:0]  code,
  input  logic signed [7:0]  glyph_x_offset,
  input  logic signed [7:0]  glyph_y_offset,
  input  logic [7:0]         glyph_width,
  input  logic [7:0]         glyph_height,
  input  logic [11:0]        atlas_x,
  input  logic [11:0]        atlas_y,
  input  logic [7:0]         x_advance,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_idx,
  input  logic [15:0]        cfg_val,
  output logic [15:0]        xl,
  output logic [15:0]        xr,
  output logic [15:0]        yt,
  output logic [15:0]        yb,
  output logic [15:0]        ul,
  output logic [15:0]        ur,
  output logic [15:0]        vt,
  output logic [15:0]        vb
);

  logic [13:0] win_w_r, win_h_r;
  logic [15:0] scale_r;
  logic [12:0] atl_w_r, atl_h_r;
  logic signed [12:0] org_x_r, org_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_w_r <= 14'd640;
      win_h_r <= 14'd480;
      scale_r <= 16'd256;
      atl_w_r <= 13'd256;
      atl_h_r <= 13'd256;
      org_x_r <= '0;
      org_y_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_WINDOW_WIDTH:  win_w_r <= cfg_val[13:0];
        REG_WINDOW_HEIGHT: win_h_r <= cfg_val[13:0];
        REG_TEXT_SCALE:    scale_r <= cfg_val;
        REG_ATLAS_WIDTH:   atl_w_r <= cfg_val[12:0];
        REG_ATLAS_HEIGHT:  atl_h_r <= cfg_val[12:0];
        REG_ORIGIN_X:      org_x_r <= cfg_val[12:0];
        REG_ORIGIN_Y:      org_y_r <= cfg_val[12:0];
        default: ;
      endcase
    end
  end

  // Glyph store: metrics and atlas position in one memory, valid bits in flops.
  logic [63:0] glyph_mem [GLYPH_ENTRIES];
  logic [GLYPH_ENTRIES-1:0] gvalid_r;
  logic [63:0] rd_r;
  logic        rd_valid_r;
  logic        in_range;
  logic [IDX_W-1:0] idx;

  assign in_range = ({{(32-CODE_W){1'b0}}, code} < 32'(GLYPH_ENTRIES));
  assign idx      = IDX_W'(code);

  always_ff @(posedge clk) begin
    if (cmd.load && in_range)
      glyph_mem[idx] <= {x_advance, atlas_y, atlas_x, glyph_height, glyph_width,
                         glyph_y_offset, glyph_x_offset};
    if (cmd.lookup)
      rd_r <= glyph_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gvalid_r   <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (cmd.load && in_range)
        gvalid_r[idx] <= 1'b1;
      if (cmd.lookup)
        rd_valid_r <= in_range && gvalid_r[idx];
    end
  end

  logic signed [7:0]  m_xo, m_yo;
  logic [7:0]  m_w, m_h, m_adv;
  logic [11:0] m_ax, m_ay;
  assign m_xo  = rd_r[7:0];
  assign m_yo  = rd_r[15:8];
  assign m_w   = rd_r[23:16];
  assign m_h   = rd_r[31:24];
  assign m_ax  = rd_r[43:32];
  assign m_ay  = rd_r[55:44];
  assign m_adv = rd_r[63:56];

  logic signed [15:0] cur_r;
  always_ff @(posedge clk) begin
    if (!rst_n)
      cur_r <= '0;
    else if (cmd.first)
      cur_r <= 16'(org_x_r);
    else if (cmd.advance) begin
      if ((32'(cur_r) + $signed({24'd0, m_adv})) > 32'sd32767)
        cur_r <= 16'sd32767;
      else
        cur_r <= cur_r + $signed({8'd0, m_adv});
    end
  end

  // Operand selection: pixel or texel times factor over divisor.
  logic signed [17:0] pix;
  logic [16:0] factor;
  logic [13:0] den;
  logic        is_pos;
  always_comb begin
    pix    = '0;
    factor = '0;
    den    = 14'd1;
    is_pos = 1'b1;
    case (cmd.sel)
      Q_XL: begin pix = 18'(cur_r) + 18'(m_xo); factor = {1'b0, scale_r};
                  den = win_w_r; end
      Q_XR: begin pix = 18'(cur_r) + 18'(m_xo) + $signed({10'd0, m_w});
                  factor = {1'b0, scale_r}; den = win_w_r; end
      Q_YT: begin pix = 18'(org_y_r) - 18'(m_yo); factor = {1'b0, scale_r};
                  den = win_h_r; end
      Q_YB: begin pix = 18'(org_y_r) - 18'(m_yo) - $signed({10'd0, m_h});
                  factor = {1'b0, scale_r}; den = win_h_r; end
      Q_UL: begin pix = $signed({6'd0, m_ax}); factor = 17'd65536;
                  den = {1'b0, atl_w_r}; is_pos = 1'b0; end
      Q_UR: begin pix = $signed({6'd0, m_ax}) + $signed({10'd0, m_w});
                  factor = 17'd65536; den = {1'b0, atl_w_r}; is_pos = 1'b0; end
      Q_VT: begin pix = $signed({6'd0, m_ay}); factor = 17'd65536;
                  den = {1'b0, atl_h_r}; is_pos = 1'b0; end
      Q_VB: begin pix = $signed({6'd0, m_ay}) + $signed({10'd0, m_h});
                  factor = 17'd65536; den = {1'b0, atl_h_r}; is_pos = 1'b0; end
      default: ;
    endcase
    if (den == 14'd0)
      den = 14'd1;
  end

  // Numerator magnitude is |pix| * factor * 16 (positions) or * 32768 (uvs,
  // factor holds 2*32768 so the extra bit is shifted out below); half the
  // divisor is added for rounding.
  logic [17:0] pmag;
  logic [34:0] mprod;
  logic [NUM_W-1:0] prod_r, num;
  logic        neg_r;
  logic [13:0] den_r;
  assign pmag  = pix[17] ? 18'(-pix) : 18'(pix);
  assign mprod = pmag * factor;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= is_pos ? {1'b0, mprod, 4'd0} : {6'd0, mprod[34:1]};
      neg_r  <= pix[17];
      den_r  <= den;
    end
  end

  assign num = prod_r + NUM_W'(den_r >> 1);

  logic             div_done;
  logic [QUO_W-1:0] quo;

  gqv_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (num),
    .den   (den_r),
    .done  (div_done),
    .quo   (quo)
  );

  logic signed [QUO_W+1:0] sq, res;
  logic [15:0] sat;
  always_comb begin
    sq  = neg_r ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
    res = sq;
    sat = '0;
    case (cmd.sel)
      Q_XL, Q_XR: res = sq - 4096;
      Q_YT, Q_YB: res = sq + 4096;
      default: ;
    endcase
    if (cmd.sel == Q_UL || cmd.sel == Q_UR || cmd.sel == Q_VT || cmd.sel == Q_VB)
      sat = (res > 65535) ? 16'hFFFF : 16'(res);
    else if (res > 32767)
      sat = 16'h7FFF;
    else if (res < -32768)
      sat = 16'h8000;
    else
      sat = 16'(res);
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      case (cmd.sel)
        Q_XL: xl <= sat;
        Q_XR: xr <= sat;
        Q_YT: yt <= sat;
        Q_YB: yb <= sat;
        Q_UL: ul <= sat;
        Q_UR: ur <= sat;
        Q_VT: vt <= sat;
        Q_VB: vb <= sat;
        default: ;
      endcase
    end
  end

  assign sts.valid    = rd_valid_r;
  assign sts.div_done = div_done;

endmodule

>>> sv/gqv_controller.sv
module gqv_controller
  import gqv_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic       in_mode,
  input  logic       in_first,
  output logic       in_ready,
  input  sts_t       sts,
  output cmd_t       cmd,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_unsup,
  output logic       out_last,
  output logic [2:0] out_corner
);

  typedef enum logic [2:0] {
    S_IDLE, S_LOOK, S_CHECK, S_MUL, S_DIV, S_EMIT, S_UNSUP
  } state_t;

  state_t      state_r, state_nxt;
  qsel_t       sel_r, sel_nxt;
  logic [2:0]  vtx_r, vtx_nxt;

  always_comb begin
    state_nxt   = state_r;
    sel_nxt     = sel_r;
    vtx_nxt     = vtx_r;
    cmd         = '0;
    cmd.sel     = sel_r;
    in_ready    = (state_r == S_IDLE);
    out_valid   = 1'b0;
    out_unsup   = 1'b0;
    out_last    = 1'b0;
    out_corner  = vtx_r;
    case (state_r)
      S_IDLE: if (in_fire) begin
        if (!in_mode)
          cmd.load = 1'b1;
        else begin
          cmd.lookup = 1'b1;
          cmd.first  = in_first;
          state_nxt  = S_LOOK;
        end
      end
      S_LOOK: state_nxt = S_CHECK;
      S_CHECK: begin
        sel_nxt   = Q_XL;
        state_nxt = sts.valid ? S_MUL : S_UNSUP;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (!sts.div_done && vtx_r == 3'd7)
          cmd.div_start = 1'b1;
        if (sts.div_done) begin
          cmd.store = 1'b1;
          if (sel_r == Q_VB) begin
            vtx_nxt   = 3'd0;
            state_nxt = S_EMIT;
          end else begin
            sel_nxt   = qsel_t'(sel_r + 3'd1);
            state_nxt = S_MUL;
          end
        end
      end
      S_EMIT: begin
        out_valid = 1'b1;
        out_last  = (vtx_r == 3'd5);
        if (out_ready) begin
          vtx_nxt = vtx_r + 3'd1;
          if (vtx_r == 3'd5) begin
            cmd.advance = 1'b1;
            state_nxt   = S_IDLE;
          end
        end
      end
      S_UNSUP: begin
        out_valid = 1'b1;
        out_unsup = 1'b1;
        out_last  = 1'b1;
        if (out_ready)
          state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Division is started in the first cycle of S_DIV, from the numerator registered
  // in S_MUL; vtx_r holds 7 in that cycle and 6 for the rest of S_DIV.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      sel_r     <= Q_XL;
      vtx_r     <= 3'd0;
    end else begin
      state_r   <= state_nxt;
      sel_r     <= sel_nxt;
      if (state_r == S_MUL)
        vtx_r <= 3'd7;
      else if (state_r == S_DIV && vtx_r == 3'd7)
        vtx_r <= 3'd6;
      else
        vtx_r <= vtx_nxt;
    end
  end

endmodule

>>> sv/glyph_quad_vertex_generator_unit.sv
// Channel  Direction  Handshake                   Payload
// in_      slave      in_tvalid / in_tready       in_tdata, in_tuser
// out_     master     out_tvalid / out_tready     out_tdata, out_tuser, out_tlast
// cfg_     slave      cfg_valid / cfg_ready       cfg_index, cfg_data
//
// A load transfer writes the glyph store and leaves in_tready high. A placed
// character passes through lookup, then eight quotients in turn (numerator,
// divider start, 40 quotient bits from one shared bit-serial divider, store),
// then six vertex transfers; the next character is accepted only after the
// last of them. An unknown character gives one transfer after its lookup.
// Reset is synchronous, active low; the glyph store needs no clearing pass,
// its valid bits reset at once. A low out_tready holds the presented vertex
// and the state machine, and in_tready stays low until the final vertex
// transfer.
module glyph_quad_vertex_generator_unit
  import gqv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // bits from 0: char_code[7:0], glyph_x_offset, glyph_y_offset, glyph_width,
  // glyph_height, atlas_x[12], atlas_y[12], x_advance; 72 bits
  input  logic [71:0] in_tdata,
  // bit 0 mode, bit 1 first
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // bits from 0: pos_x, pos_y, tex_u, tex_v
  output logic [63:0] out_tdata,
  // bit 0 unsupported
  output logic        out_tuser,
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;
  logic in_fire, unsup;
  logic [2:0] corner;
  logic [15:0] xl, xr, yt, yb, ul, ur, vt, vb;

  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  gqv_controller u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .in_mode    (in_tuser[0]),
    .in_first   (in_tuser[1]),
    .in_ready   (in_tready),
    .sts        (sts),
    .cmd        (cmd),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_unsup  (unsup),
    .out_last   (out_tlast),
    .out_corner (corner)
  );

  gqv_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .code           (in_tdata[7:0]),
    .glyph_x_offset (in_tdata[15:8]),
    .glyph_y_offset (in_tdata[23:16]),
    .glyph_width    (in_tdata[31:24]),
    .glyph_height   (in_tdata[39:32]),
    .atlas_x        (in_tdata[51:40]),
    .atlas_y        (in_tdata[63:52]),
    .x_advance      (in_tdata[71:64]),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_idx        (cfg_index),
    .cfg_val        (cfg_data),
    .xl (xl), .xr (xr), .yt (yt), .yb (yb),
    .ul (ul), .ur (ur), .vt (vt), .vb (vb)
  );

  // Vertex order BR, TR, TL, TL, BL, BR.
  logic right, bottom;
  always_comb begin
    right  = 1'b0;
    bottom = 1'b0;
    case (corner)
      3'd0: begin right = 1'b1; bottom = 1'b1; end
      3'd1: right = 1'b1;
      3'd4: bottom = 1'b1;
      3'd5: begin right = 1'b1; bottom = 1'b1; end
      default: ;
    endcase
    if (unsup)
      out_tdata = '0;
    else
      out_tdata = {bottom ? vb : vt, right ? ur : ul,
                   bottom ? yb : yt, right ? xr : xl};
  end

  assign out_tuser = unsup;

endmodule
